// ===== hdl/b64dec_pkg.sv =====
package b64dec_pkg;

  localparam int SIZE_W = 16;
  localparam int LEN_W  = SIZE_W + 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Final status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;
  localparam logic [1:0] ST_SIZE     = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_STRICT = 1'b0;
  localparam logic CFG_SIZE   = 1'b1;

  localparam logic [SIZE_W-1:0] EXPECTED_SIZE_RST = SIZE_W'(16);

  typedef struct packed {
    logic       char_present;
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic              strict_mode;
    logic [SIZE_W-1:0] expected_size;
  } cfg_t;

  // Up to two results come out of one item.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } core_res_t;

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] alpha_dec(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

  // Saturating count that keeps its value mod 4 at the top.
  function automatic logic [LEN_W-1:0] count_up(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    if (n == {LEN_W{1'b1}}) begin
      r = n - LEN_W'(3);
    end else begin
      r = n + LEN_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== hdl/b64dec_core.sv =====
module b64dec_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  b64dec_pkg::in_item_t  item,
  input  b64dec_pkg::cfg_t      cfg,
  output b64dec_pkg::core_res_t res
);
  import b64dec_pkg::*;

  logic [1:0]       gp_r, gp_nxt;
  logic [5:0]       acc_r, acc_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic             stop_r, stop_nxt;
  logic             bad_r, bad_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;

  logic [6:0]       av;
  logic [5:0]       v;
  logic             nalpha;
  logic [7:0]       dbyte;
  logic             emit;
  logic [LEN_W-1:0] quads;
  logic [LEN_W-1:0] decoded;
  logic [1:0]       st;
  out_item_t        r_data;
  out_item_t        r_stat;

  always_comb begin
    gp_nxt   = gp_r;
    acc_nxt  = acc_r;
    pad_nxt  = pad_r;
    stop_nxt = stop_r;
    bad_nxt  = bad_r;
    plen_nxt = plen_r;
    tlen_nxt = tlen_r;
    av       = alpha_dec(item.char_code);
    v        = av[5:0];
    nalpha   = av[6];
    dbyte    = 8'd0;
    emit     = 1'b0;

    if (item.char_present) begin
      tlen_nxt = count_up(tlen_r);
      if (item.char_code == PAD_CHAR) begin
        if (pad_r != 2'd3) begin
          pad_nxt = pad_r + 2'd1;
        end
        stop_nxt = 1'b1;
      end else begin
        pad_nxt = 2'd0;
        if (nalpha || stop_r) begin
          bad_nxt = 1'b1;
        end
        if (nalpha) begin
          stop_nxt = 1'b1;
        end else if (!stop_r) begin
          case (gp_r)
            2'd1: dbyte = {acc_r, v[5:4]};
            2'd2: dbyte = {acc_r[3:0], v[5:2]};
            2'd3: dbyte = {acc_r[1:0], v};
            default: dbyte = 8'd0;
          endcase
          emit     = (gp_r != 2'd0);
          acc_nxt  = v;
          gp_nxt   = gp_r + 2'd1;
          plen_nxt = count_up(plen_r);
        end
      end
    end

    // Status is judged on the state after this item.
    quads   = LEN_W'(tlen_nxt[LEN_W-1:2]);
    decoded = (quads << 1) + quads - LEN_W'(pad_nxt);
    if (tlen_nxt == '0) begin
      decoded = '0;
    end
    if (!cfg.strict_mode) begin
      st = (plen_nxt[1:0] == 2'd1) ? ST_BAD_LEN : ST_OK;
    end else if (tlen_nxt[1:0] != 2'd0) begin
      st = ST_BAD_LEN;
    end else if (pad_nxt == 2'd3) begin
      st = ST_BAD_LEN;
    end else if (decoded != LEN_W'(cfg.expected_size)) begin
      st = ST_SIZE;
    end else if (bad_nxt) begin
      st = ST_BAD_CHAR;
    end else begin
      st = ST_OK;
    end

    if (item.is_last) begin
      gp_nxt   = 2'd0;
      acc_nxt  = 6'd0;
      pad_nxt  = 2'd0;
      stop_nxt = 1'b0;
      bad_nxt  = 1'b0;
      plen_nxt = '0;
      tlen_nxt = '0;
    end

    r_data.kind        = KIND_DATA;
    r_data.data_byte   = dbyte;
    r_data.status      = ST_OK;
    r_data.last_of_run = !item.is_last;
    r_stat.kind        = KIND_STATUS;
    r_stat.data_byte   = 8'd0;
    r_stat.status      = st;
    r_stat.last_of_run = 1'b1;

    res.r0  = r_data;
    res.r1  = r_stat;
    res.cnt = 2'd0;
    if (fire) begin
      if (emit && item.is_last) begin
        res.cnt = 2'd2;
      end else if (emit) begin
        res.cnt = 2'd1;
      end else if (item.is_last) begin
        res.cnt = 2'd1;
        res.r0  = r_stat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r   <= 2'd0;
      acc_r  <= 6'd0;
      pad_r  <= 2'd0;
      stop_r <= 1'b0;
      bad_r  <= 1'b0;
      plen_r <= '0;
      tlen_r <= '0;
    end else if (fire) begin
      gp_r   <= gp_nxt;
      acc_r  <= acc_nxt;
      pad_r  <= pad_nxt;
      stop_r <= stop_nxt;
      bad_r  <= bad_nxt;
      plen_r <= plen_nxt;
      tlen_r <= tlen_nxt;
    end
  end

endmodule

// ===== hdl/b64dec_rq.sv =====
module b64dec_rq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b64dec_pkg::core_res_t  push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output b64dec_pkg::out_item_t  out_item
);
  import b64dec_pkg::*;

  // Four-entry result queue; it takes up to two results and gives one per cycle while out_stall is low.
  out_item_t  mem_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] wp1;

  assign out_valid = (cnt_r != 3'd0);
  assign out_item  = mem_r[rp_r];
  assign room      = (cnt_r <= 3'd2);
  assign pop       = out_valid && !out_stall;
  assign wp1       = wp_r + 2'd1;

  always_comb begin
    wp_nxt  = wp_r + push.cnt;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(push.cnt) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/base64_decoder_size_checked_top.sv =====
// An accepted item is held in the input register, decoded by the core, and
// its results are written into the four-entry result queue.
// Throughput: one item per cycle while the queue has room; an item with a
// data byte and the final status leaves two results, drained one per cycle
// while out_stall is low. Reset (rst_n low, synchronous) clears the decode
// state, queue and input valid flag, and sets strict mode, expected size 16.
module base64_decoder_size_checked_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  b64dec_pkg::in_item_t               in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output b64dec_pkg::out_item_t              out_item,
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [b64dec_pkg::SIZE_W-1:0]      cfg_wdata
);
  import b64dec_pkg::*;

  cfg_t      cfg_r;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      room;
  logic      fire;
  core_res_t core_o;

  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strict_mode   <= 1'b1;
      cfg_r.expected_size <= EXPECTED_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STRICT: cfg_r.strict_mode   <= cfg_wdata[0];
        CFG_SIZE:   cfg_r.expected_size <= cfg_wdata;
        default:    cfg_r               <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  b64dec_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (core_o)
  );

  b64dec_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_o),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> core_o.cnt == 2'd0)
    else $error("results pushed without an item in process");

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_STATUS |-> out_item.last_of_run)
    else $error("status result not marked as the last of its run");

  a_data_then_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.kind == KIND_DATA && !out_item.last_of_run
    |=> out_valid && out_item.kind == KIND_STATUS)
    else $error("data byte of a closing item not followed by its status");
`endif

endmodule
